// ----- hw/rtl/perfect_power_exponent_mask_macros.svh -----
// assertion macros for the perfect power exponent mask block
// used by the top level only, no other dependencies
`ifndef PERFECT_POWER_EXPONENT_MASK_MACROS_SVH
`define PERFECT_POWER_EXPONENT_MASK_MACROS_SVH
`ifndef SYNTHESIS
`define PPEM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ppem assertion failed");
`define PPEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ppem assertion failed");
`else
`define PPEM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PPEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/ppem_pkg.sv -----
// shared types and constants for the perfect power exponent mask block
// no dependencies
package ppem_pkg;

    localparam int MASK_BITS      = 30;
    localparam int OUT_TDATA_BITS = ((MASK_BITS + 7) / 8) * 8;
    localparam int CFG_BITS       = 5;
    localparam int EXP_BITS       = 5;
    localparam int CHUNK_BITS     = 32;

    localparam logic [CFG_BITS-1:0] COUNT_RESET = CFG_BITS'(30);

    typedef struct packed {
        logic load;
        logic exp_init;
        logic mid_set;
        logic mul_step;
        logic check;
        logic exp_next;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic search_empty;
        logic chunk_last;
        logic over;
        logic pow_last;
        logic eq;
        logic exp_last;
    } status_t;

endpackage

// ----- hw/rtl/perfect_power_exponent_mask.sv -----
// perfect power exponent mask: one signed word in, one exponent bitmask word out.
// s_axis carries the value; m_axis carries power_mask, bit k for exponent k+2.
// cfg_valid/cfg_ready/cfg_data write exponent_count (exponents 2..count+1).
// exponent_count resets to 30; write it only while no word is in flight.
// a word is taken only in idle; each exponent runs a binary search over
// bases 1..2^(VALUE_BITS/2)-1 of at most VALUE_BITS/2 steps.
// a step sets the midpoint in MID, then runs up to e multiplies, each MUL over all
// chunks and then CHECK, chunks = ceil((VALUE_BITS-1)/32); a power stops once it passes the value;
// each exponent also passes EXP_START and NEXT to start the search and move on.
// the single shared multiplier sets the time per word; a nonpositive value or
// a zero count skips the search and goes from EXP_START straight to DONE.
// the result sits in an output register, so the next word is accepted while
// it waits; a finished word stalls only while that register is still full.
// reset is synchronous, active low, and returns the block to idle.
// depends on ppem_pkg, ppem_ctrl, ppem_dp and the macros header
`include "perfect_power_exponent_mask_macros.svh"
module perfect_power_exponent_mask #(
    parameter int MAX_EXPONENTS = 30,
    parameter int VALUE_BITS    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // value
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // power_mask
    output logic [ppem_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppem_pkg::CFG_BITS-1:0]       cfg_data
);

    localparam int LIM_CAP = (MAX_EXPONENTS < ppem_pkg::MASK_BITS) ?
                             MAX_EXPONENTS : ppem_pkg::MASK_BITS;

    logic [ppem_pkg::CFG_BITS-1:0]  count_reg;
    logic                           out_valid_reg;
    logic [ppem_pkg::MASK_BITS-1:0] out_mask_reg;
    logic [ppem_pkg::MASK_BITS-1:0] dp_mask;
    logic                           out_busy;
    ppem_pkg::cmd_t                 cmd;
    ppem_pkg::status_t              status;

    assign out_busy  = out_valid_reg && !m_axis_tready;
    assign cfg_ready = 1'b1;

    ppem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_busy (out_busy),
        .status   (status),
        .cmd      (cmd)
    );

    ppem_dp #(
        .VALUE_BITS    (VALUE_BITS),
        .MAX_EXPONENTS (MAX_EXPONENTS)
    ) u_dp (
        .aclk   (aclk),
        .value  (s_axis_tdata[VALUE_BITS-1:0]),
        .count  (count_reg),
        .cmd    (cmd),
        .status (status),
        .mask   (dp_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= ppem_pkg::COUNT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_mask_reg <= dp_mask;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(ppem_pkg::OUT_TDATA_BITS - ppem_pkg::MASK_BITS){1'b0}},
                            out_mask_reg};

    // busy from the word after a word is taken
    `PPEM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PPEM_ASSERT_NEXT(a_emit_shows_word, aclk, aresetn, cmd.emit, m_axis_tvalid)
    `PPEM_ASSERT_IMPL(a_mask_in_range, aclk, aresetn, m_axis_tvalid,
        (out_mask_reg >> LIM_CAP) == '0)
    `PPEM_ASSERT_IMPL(a_emit_only_free, aclk, aresetn, cmd.emit, !out_busy)

endmodule

// ----- hw/rtl/ppem_dp.sv -----
// datapath: value, search bounds, early-stopping power with one shared multiplier
// depends on ppem_pkg
module ppem_dp #(
    parameter int VALUE_BITS    = 32,
    parameter int MAX_EXPONENTS = 30
) (
    input  logic                           aclk,
    input  logic [VALUE_BITS-1:0]          value,
    input  logic [ppem_pkg::CFG_BITS-1:0]  count,
    input  ppem_pkg::cmd_t                 cmd,
    output ppem_pkg::status_t              status,
    output logic [ppem_pkg::MASK_BITS-1:0] mask
);

    localparam int NB      = VALUE_BITS - 1;
    localparam int H       = VALUE_BITS / 2;
    localparam int PW      = NB + H;
    localparam int CW      = ppem_pkg::CHUNK_BITS;
    localparam int NCH     = (NB + CW - 1) / CW;
    localparam int NCHW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int LIM_CAP = (MAX_EXPONENTS < ppem_pkg::MASK_BITS) ?
                             MAX_EXPONENTS : ppem_pkg::MASK_BITS;
    localparam int EB      = ppem_pkg::EXP_BITS;

    logic [NB-1:0]                  n_reg;
    logic                           pos_reg;
    logic [EB-1:0]                  limit_reg;
    logic [EB-1:0]                  k_reg;
    logic [EB-1:0]                  i_reg;
    logic [H:0]                     lo_reg;
    logic [H-1:0]                   hi_reg;
    logic [H-1:0]                   mid_reg;
    logic [NB-1:0]                  p_reg;
    logic [PW-1:0]                  acc_reg;
    logic [NCHW-1:0]                ch_reg;
    logic [ppem_pkg::MASK_BITS-1:0] mask_reg;

    logic [NCH*CW-1:0] p_pad;
    logic [CW-1:0]     chunk;
    logic [CW+H-1:0]   prod;
    logic [PW-1:0]     term;
    logic [H:0]        mid_w;
    logic [EB-1:0]     limit_w;
    logic [EB-1:0]     k_inc;

    assign p_pad   = (NCH*CW)'(p_reg);
    assign chunk   = p_pad[ch_reg*CW +: CW];
    assign prod    = chunk * mid_reg;
    assign term    = PW'({{PW{1'b0}}, prod} << (ch_reg * CW));
    assign mid_w   = lo_reg + (({1'b0, hi_reg} - lo_reg) >> 1);
    assign limit_w = (count > EB'(LIM_CAP)) ? EB'(LIM_CAP) : count;
    assign k_inc   = k_reg + EB'(1);

    assign status.skip         = !pos_reg || (limit_reg == '0);
    assign status.search_empty = lo_reg > {1'b0, hi_reg};
    assign status.chunk_last   = ch_reg == NCHW'(NCH - 1);
    assign status.over         = acc_reg > PW'(n_reg);
    assign status.eq           = acc_reg == PW'(n_reg);
    assign status.pow_last     = i_reg == k_inc;
    assign status.exp_last     = k_inc == limit_reg;
    assign mask                = mask_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg     <= value[NB-1:0];
            pos_reg   <= !value[VALUE_BITS-1] && (value[NB-1:0] != '0);
            limit_reg <= limit_w;
            k_reg     <= '0;
            mask_reg  <= '0;
        end
        if (cmd.exp_init) begin
            lo_reg <= (H+1)'(1);
            hi_reg <= '1;
        end
        if (cmd.mid_set) begin
            mid_reg <= mid_w[H-1:0];
            p_reg   <= NB'(1);
            i_reg   <= '0;
            ch_reg  <= '0;
        end
        if (cmd.mul_step) begin
            acc_reg <= ((ch_reg == '0) ? '0 : acc_reg) + term;
            ch_reg  <= status.chunk_last ? '0 : ch_reg + NCHW'(1);
        end
        if (cmd.check) begin
            if (status.over) begin
                hi_reg <= mid_reg - H'(1);
            end else begin
                p_reg <= NB'(acc_reg);
                i_reg <= i_reg + EB'(1);
                if (status.pow_last) begin
                    if (status.eq) begin
                        mask_reg[k_reg] <= 1'b1;
                    end else begin
                        lo_reg <= (H+1)'(mid_reg) + (H+1)'(1);
                    end
                end
            end
        end
        if (cmd.exp_next) begin
            k_reg <= k_inc;
        end
    end

endmodule

// ----- hw/rtl/ppem_ctrl.sv -----
// controller: sequences exponents, search steps and multiplies
// depends on ppem_pkg
module ppem_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_busy,
    input  ppem_pkg::status_t status,
    output ppem_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE, EXP_START, MID, MUL, CHECK, NEXT, DONE
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (in_valid && in_ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = EXP_START;
                end
            end
            EXP_START: begin
                if (status.skip) begin
                    state_next = DONE;
                end else begin
                    cmd.exp_init = 1'b1;
                    state_next   = MID;
                end
            end
            MID: begin
                if (status.search_empty) begin
                    state_next = NEXT;
                end else begin
                    cmd.mid_set = 1'b1;
                    state_next  = MUL;
                end
            end
            MUL: begin
                cmd.mul_step = 1'b1;
                if (status.chunk_last) begin
                    state_next = CHECK;
                end
            end
            CHECK: begin
                cmd.check = 1'b1;
                priority if (status.over) begin
                    state_next = MID;
                end else if (status.pow_last) begin
                    state_next = status.eq ? NEXT : MID;
                end else begin
                    state_next = MUL;
                end
            end
            NEXT: begin
                if (status.exp_last) begin
                    state_next = DONE;
                end else begin
                    cmd.exp_next = 1'b1;
                    state_next   = EXP_START;
                end
            end
            DONE: begin
                if (!out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            in_ready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ----- verif/perfect_power_exponent_mask_checker.sv -----
`timescale 1ns / 100ps
// result checker for the perfect power exponent mask block: watches the value,
// result and exponent count channels, predicts each power mask and compares it
// depends on ppem_pkg
module perfect_power_exponent_mask_checker #(
    parameter int MAX_EXPONENTS = 30,
    parameter int VALUE_BITS    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // value
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // power_mask
    input  logic [ppem_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ppem_pkg::CFG_BITS-1:0]       cfg_data,
    output int                                  fail_count,
    output int                                  masks_pending
);

    localparam longint unsigned ROOT_CEIL = (64'd1 << (VALUE_BITS / 2)) - 1;

    typedef struct {
        logic [VALUE_BITS-1:0]          value;
        logic [ppem_pkg::MASK_BITS-1:0] mask;
    } mask_entry_t;

    mask_entry_t                   expected_masks[$];
    logic [ppem_pkg::CFG_BITS-1:0] exponent_count;

    // bit k: value is an exact (k+2)-th power, found by searching the base
    function automatic logic [ppem_pkg::MASK_BITS-1:0] predict_power_mask(
        input logic [VALUE_BITS-1:0]         value,
        input logic [ppem_pkg::CFG_BITS-1:0] count
    );
        logic [ppem_pkg::MASK_BITS-1:0] mask;
        longint unsigned                n, lo, hi, mid, p;
        int                             tested, k, i;
        bit                             found;
        mask   = '0;
        tested = (count > MAX_EXPONENTS) ? MAX_EXPONENTS : int'(count);
        if (!value[VALUE_BITS-1] && value != '0) begin
            n = 64'(value);
            for (k = 0; k < tested; k++) begin
                lo    = 1;
                hi    = ROOT_CEIL;
                found = 1'b0;
                while (!found && lo <= hi) begin
                    mid = (lo + hi) >> 1;
                    p   = 1;
                    // stop multiplying once past the value
                    for (i = 0; i < k + 2 && p <= n; i++)
                        p = p * mid;
                    if (p == n)
                        found = 1'b1;
                    else if (p > n)
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
                mask[k] = found;
            end
        end
        return mask;
    endfunction

    always @(posedge aclk) begin : monitor
        mask_entry_t head;
        mask_entry_t fresh;
        if (!aresetn) begin
            expected_masks.delete();
            exponent_count = ppem_pkg::COUNT_RESET;
            fail_count    <= 0;
            masks_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                exponent_count = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_masks.size() == 0) begin
                    $display("%0t: power_mask expected none, actual %h", $time,
                             m_axis_tdata[ppem_pkg::MASK_BITS-1:0]);
                    fail_count <= fail_count + 1;
                end else begin
                    head = expected_masks.pop_front();
                    if (m_axis_tdata[ppem_pkg::MASK_BITS-1:0] !== head.mask) begin
                        $display("%0t: value %0d power_mask expected %h, actual %h", $time,
                                 $signed(head.value), head.mask,
                                 m_axis_tdata[ppem_pkg::MASK_BITS-1:0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                fresh.value = s_axis_tdata[VALUE_BITS-1:0];
                fresh.mask  = predict_power_mask(fresh.value, exponent_count);
                expected_masks.push_back(fresh);
            end
            masks_pending <= expected_masks.size();
        end
    end

endmodule

// ----- verif/perfect_power_exponent_mask_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the perfect power exponent mask block: clock, reset, value
// stimulus, result back-pressure, exponent count writes and the verdict
// depends on ppem_pkg, the block and perfect_power_exponent_mask_checker
module perfect_power_exponent_mask_tb;

    localparam int VALUE_BITS    = 32;
    localparam int MAX_EXPONENTS = 30;
    localparam int IN_BITS       = ((VALUE_BITS + 7) / 8) * 8;
    localparam int STALL_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 64;

    localparam logic [ppem_pkg::CFG_BITS-1:0] COUNT_NONE = '0;
    localparam logic [ppem_pkg::CFG_BITS-1:0] COUNT_ONE  = ppem_pkg::CFG_BITS'(1);
    localparam logic [ppem_pkg::CFG_BITS-1:0] COUNT_TOP  = '1;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [IN_BITS-1:0]                  s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [ppem_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [ppem_pkg::CFG_BITS-1:0]       cfg_data;

    int fail_count;
    int masks_pending;
    int quiet_cycles = 0;
    bit steady_flow  = 1'b0;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;
    bit rx_holding   = 1'b0;

    logic [VALUE_BITS-1:0] edge_values [0:21] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'd4,
        32'd8, 32'd27, 32'd64, 32'd4096, 32'd65536, 32'd1000000, 32'h4000_0000,
        32'd2147395600, 32'd2147395599, 32'd2147395601, 32'd1162261467,
        32'd1977326743, 32'd15, 32'd17, 32'h3FFF_FFFF
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    perfect_power_exponent_mask #(
        .MAX_EXPONENTS (MAX_EXPONENTS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    perfect_power_exponent_mask_checker #(
        .MAX_EXPONENTS (MAX_EXPONENTS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .masks_pending (masks_pending)
    );

    function automatic int pick_gap();
        int unsigned r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    // exact powers and their neighbors most often, then nonpositive, small and raw
    function automatic logic [VALUE_BITS-1:0] random_value();
        int unsigned     pick, e, base;
        longint unsigned v;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            e    = $urandom_range(2, 30);
            base = $urandom_range(2, 1 << (30 / e));
            v    = 1;
            repeat (e) v = v * base;
            case ($urandom_range(0, 7))
                0: v = v - 1;
                1: v = v + 1;
                default: ;
            endcase
            return v[VALUE_BITS-1:0];
        end
        if (pick < 55)
            return $urandom | 32'h8000_0000;
        if (pick < 60)
            return '0;
        if (pick < 75)
            return $urandom_range(1, 5000);
        return $urandom;
    endfunction

    task automatic push_value(input logic [VALUE_BITS-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'(value);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic write_exponent_count(input logic [ppem_pkg::CFG_BITS-1:0] count);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (masks_pending != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // result side back-pressure, with one long hold-off on request
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                rx_holding = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_holding = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (edge_values[i]) push_value(edge_values[i]);

        // count above the limit saturates
        write_exponent_count(COUNT_TOP);
        push_value(32'd1);
        push_value(32'h4000_0000);
        push_value(32'd65536);
        repeat (22) push_value(random_value());

        write_exponent_count(COUNT_NONE);
        push_value(32'd1);
        push_value(32'h4000_0000);
        repeat (8) push_value(random_value());

        write_exponent_count(COUNT_ONE);
        repeat (25) push_value(random_value());

        // result side stalls while words keep coming
        hold_request = 1'b1;
        wait (rx_holding);
        repeat (12) begin
            if ($urandom_range(0, 3) == 0)
                push_value($urandom_range(1, 300));
            else
                push_value($urandom | 32'h8000_0000);
        end

        write_exponent_count(ppem_pkg::CFG_BITS'($urandom_range(2, 29)));
        steady_flow = 1'b1;
        repeat (24) push_value(random_value());
        steady_flow = 1'b0;

        write_exponent_count(ppem_pkg::COUNT_RESET);
        repeat (24) push_value(random_value());

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (masks_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
